// ----- hw/rtl/rthsv_pkg.sv -----
`timescale 1ns / 1ps

package rthsv_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned HueW   = 16;
  localparam int unsigned SatW   = 17;
  localparam int unsigned DenW   = 11;  // 6 * spread <= 1530
  localparam int unsigned NumDivCells = HueW;  // one quotient bit per cell

  typedef struct packed {
    logic [ChanW-1:0] sat_rem;
    logic [ChanW-1:0] sat_div;
    logic [SatW-1:0]  sat_q;
    logic [DenW-1:0]  hue_rem;
    logic [DenW-1:0]  hue_den;
    logic [HueW-1:0]  hue_q;
    logic [ChanW-1:0] brightness;
    logic             is_gray;
  } stage_t;

endpackage

// ----- hw/rtl/rthsv_if.sv -----
`timescale 1ns / 1ps

interface rthsv_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rthsv_hsv_if;
  logic        valid;
  logic        ready;
  logic [15:0] hue;
  logic [16:0] saturation;
  logic [7:0]  brightness;
  logic        is_gray;

  modport source (output valid, output hue, output saturation, output brightness,
                  output is_gray, input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  input is_gray, output ready);
endinterface

// ----- hw/rtl/rthsv_prep.sv -----
`timescale 1ns / 1ps

module rthsv_prep (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  logic [7:0]      red_i,
  input  logic [7:0]      green_i,
  input  logic [7:0]      blue_i,
  output logic            valid_o,
  input  logic            ready_i,
  output rthsv_pkg::stage_t data_o
);
  import rthsv_pkg::*;

  logic             valid_q;
  stage_t           data_q, data_d;
  logic [ChanW-1:0] top, bot, spread;
  logic [DenW-1:0]  d11, den, num;
  logic [DenW-1:0]  num_g, num_b;
  logic             gray;

  always_comb begin
    top = (red_i >= green_i) ? red_i : green_i;
    if (blue_i > top) begin
      top = blue_i;
    end
    bot = (red_i <= green_i) ? red_i : green_i;
    if (blue_i < bot) begin
      bot = blue_i;
    end
    spread = top - bot;
    gray   = (spread == '0);
    d11    = {{(DenW-ChanW){1'b0}}, spread};
    den    = (d11 << 2) + (d11 << 1);
    // final values are non-negative and below den, so wrapping in between is harmless
    num_g  = {d11[DenW-2:0], 1'b0} + {3'b0, blue_i} - {3'b0, red_i};
    num_b  = {d11[DenW-3:0], 2'b0} + {3'b0, red_i} - {3'b0, green_i};

    if (red_i == top) begin
      if (green_i >= blue_i) begin
        num = {3'b0, green_i - blue_i};
      end else begin
        num = den - {3'b0, blue_i - green_i};
      end
    end else if (green_i == top) begin
      num = num_g;
    end else begin
      num = num_b;
    end

    // Gray pixel: zero remainders with divisor one keep both quotients at zero
    data_d.is_gray    = gray;
    data_d.brightness = top;
    data_d.sat_div    = gray ? ChanW'(1) : top;
    data_d.hue_den    = gray ? DenW'(1) : den;
    data_d.hue_rem    = gray ? '0 : num;
    data_d.hue_q      = '0;
    // spread <= top, so the integer bit of the saturation is settled here
    if (!gray && spread == top) begin
      data_d.sat_q   = SatW'(1);
      data_d.sat_rem = '0;
    end else begin
      data_d.sat_q   = '0;
      data_d.sat_rem = gray ? '0 : spread;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- hw/rtl/rthsv_div_cell.sv -----
`timescale 1ns / 1ps

module rthsv_div_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  rthsv_pkg::stage_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output rthsv_pkg::stage_t data_o
);
  import rthsv_pkg::*;

  logic             valid_q;
  stage_t           data_q, data_d;
  logic [ChanW:0]   sat_r2, sat_diff;
  logic [DenW:0]    hue_r2, hue_diff;
  logic             sat_bit, hue_bit;

  // One restoring-division step for both quotients
  always_comb begin
    sat_r2   = {data_i.sat_rem, 1'b0};
    sat_bit  = sat_r2 >= {1'b0, data_i.sat_div};
    sat_diff = sat_r2 - {1'b0, data_i.sat_div};
    hue_r2   = {data_i.hue_rem, 1'b0};
    hue_bit  = hue_r2 >= {1'b0, data_i.hue_den};
    hue_diff = hue_r2 - {1'b0, data_i.hue_den};

    data_d         = data_i;
    data_d.sat_rem = sat_bit ? sat_diff[ChanW-1:0] : sat_r2[ChanW-1:0];
    data_d.sat_q   = {data_i.sat_q[SatW-2:0], sat_bit};
    data_d.hue_rem = hue_bit ? hue_diff[DenW-1:0] : hue_r2[DenW-1:0];
    data_d.hue_q   = {data_i.hue_q[HueW-2:0], hue_bit};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- hw/rtl/rgb_to_hsv_converter.sv -----
`timescale 1ns / 1ps
// 17 register stages: one setup cell finding max, min and hue numerator, then 16 division
// cells, one quotient bit each.
// Throughput: one pixel per cycle while the output accepts; every cell is a register stage with its own
// valid, so a stalled output only blocks once the chain has filled.
// Reset: asynchronous, active low, clears all valid bits; data registers are not reset.
module rgb_to_hsv_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  rthsv_pix_if.sink   pix_i,
  rthsv_hsv_if.source hsv_o
);
  import rthsv_pkg::*;

  logic   valid_s [NumDivCells+1];
  logic   ready_s [NumDivCells+1];
  stage_t data_s  [NumDivCells+1];

  rthsv_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pix_i.valid),
    .ready_o (pix_i.ready),
    .red_i   (pix_i.red),
    .green_i (pix_i.green),
    .blue_i  (pix_i.blue),
    .valid_o (valid_s[0]),
    .ready_i (ready_s[0]),
    .data_o  (data_s[0])
  );

  for (genvar i = 0; i < NumDivCells; i++) begin : g_cell
    rthsv_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[i]),
      .ready_o (ready_s[i]),
      .data_i  (data_s[i]),
      .valid_o (valid_s[i+1]),
      .ready_i (ready_s[i+1]),
      .data_o  (data_s[i+1])
    );
  end

  assign ready_s[NumDivCells] = hsv_o.ready;
  assign hsv_o.valid      = valid_s[NumDivCells];
  assign hsv_o.hue        = data_s[NumDivCells].hue_q;
  assign hsv_o.saturation = data_s[NumDivCells].sat_q;
  assign hsv_o.brightness = data_s[NumDivCells].brightness;
  assign hsv_o.is_gray    = data_s[NumDivCells].is_gray;

endmodule

// ----- bench/hsv_result_checker.sv -----
`timescale 1ns / 1ps

module hsv_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  rthsv_pix_if        pix_i,
  rthsv_hsv_if        hsv_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned pixels_o,
  output int unsigned results_o,
  output int unsigned grays_o
);
  import rthsv_pkg::*;

  typedef struct packed {
    logic [HueW-1:0]  hue;
    logic [SatW-1:0]  saturation;
    logic [ChanW-1:0] brightness;
    logic             is_gray;
  } hsv_pixel_t;

  hsv_pixel_t expected_hsv_q[$];

  function automatic hsv_pixel_t convert_rgb(input logic [ChanW-1:0] r, g, b);
    hsv_pixel_t res;
    int top;
    int bottom;
    int spread;
    int numer;
    top = r;
    if (g > top) top = g;
    if (b > top) top = b;
    bottom = r;
    if (g < bottom) bottom = g;
    if (b < bottom) bottom = b;
    spread = top - bottom;
    res.brightness = top[ChanW-1:0];
    if (spread == 0) begin
      res.hue = '0;
      res.saturation = '0;
      res.is_gray = 1'b1;
    end else begin
      res.is_gray = 1'b0;
      res.saturation = SatW'((spread * 65536) / top);
      // max priority: red, then green, then blue; numerator is over 6*spread
      if (r == top) begin
        numer = int'(g) - int'(b);
        if (numer < 0) numer += 6 * spread;
      end else if (g == top) begin
        numer = 2 * spread + int'(b) - int'(r);
      end else begin
        numer = 4 * spread + int'(r) - int'(g);
      end
      res.hue = HueW'((numer * 65536) / (6 * spread));
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    hsv_pixel_t got;
    hsv_pixel_t want;
    if (!rst_ni) begin
      expected_hsv_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      pixels_o     <= 0;
      results_o    <= 0;
      grays_o      <= 0;
    end else begin
      if (hsv_i.valid && hsv_i.ready) begin
        got = {hsv_i.hue, hsv_i.saturation, hsv_i.brightness, hsv_i.is_gray};
        results_o <= results_o + 1;
        if (expected_hsv_q.size() == 0) begin
          $display("%0t: unexpected result hue %h sat %h value %h gray %b, expected none",
                   $time, got.hue, got.saturation, got.brightness, got.is_gray);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_hsv_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected hue %h sat %h value %h gray %b,",
                     $time, want.hue, want.saturation, want.brightness, want.is_gray,
                     " actual hue %h sat %h value %h gray %b",
                     got.hue, got.saturation, got.brightness, got.is_gray);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (pix_i.valid && pix_i.ready) begin
        want = convert_rgb(pix_i.red, pix_i.green, pix_i.blue);
        expected_hsv_q.push_back(want);
        pixels_o <= pixels_o + 1;
        if (want.is_gray) grays_o <= grays_o + 1;
      end
      pending_o <= expected_hsv_q.size();
    end
  end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import rthsv_pkg::*;

  localparam int unsigned RandomPixels = 1200;
  localparam int unsigned IdleLimit    = 2000;
  localparam int unsigned HoldCycles   = 100;
  localparam int unsigned DrainCycles  = 40;
  localparam int unsigned PausePixel   = 700;
  localparam int unsigned HoldAtFirst  = 320;
  localparam int unsigned HoldAtSecond = 920;

  // corners: black, white, gray, primaries, secondaries, hue wrap, tied maxima
  localparam logic [23:0] CornerPixels [21] = '{
    24'h000000, 24'hffffff, 24'h808080, 24'hff0000, 24'h00ff00, 24'h0000ff,
    24'hffff00, 24'h00ffff, 24'hff00ff, 24'hff0001, 24'hff0100, 24'h010000,
    24'h000100, 24'h000001, 24'hfffefe, 24'hc8c864, 24'h64c8c8, 24'hc864c8,
    24'h0a141e, 24'h1e140a, 24'haa55ff
  };

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned idle_cycles;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned pixels;
  int unsigned results;
  int unsigned grays;

  rthsv_pix_if pix ();
  rthsv_hsv_if hsv ();

  rgb_to_hsv_converter i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .pix_i  (pix),
    .hsv_o  (hsv)
  );

  hsv_result_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .pix_i        (pix),
    .hsv_i        (hsv),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .pixels_o     (pixels),
    .results_o    (results),
    .grays_o      (grays)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic send_pixel(input logic [ChanW-1:0] r, g, b);
    pix.valid <= 1'b1;
    pix.red   <= r;
    pix.green <= g;
    pix.blue  <= b;
    do @(posedge clk); while (!pix.ready);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    pix.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_results_drained();
    pause_sender(1);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [23:0] random_rgb();
    logic [ChanW-1:0] c [3];
    int unsigned kind;
    int unsigned hi;
    int unsigned k;
    kind = $urandom_range(0, 99);
    for (int i = 0; i < 3; i++) c[i] = 8'($urandom);
    if (kind < 10) begin
      c[1] = c[0];
      c[2] = c[0];
    end else if (kind < 25) begin
      // at least two channels share the max, exercises the priority order
      hi = $urandom_range(1, 255);
      k  = $urandom_range(0, 2);
      for (int i = 0; i < 3; i++) c[i] = (i == k) ? 8'($urandom_range(0, hi)) : 8'(hi);
    end else if (kind < 35) begin
      for (int i = 1; i < 3; i++)
        c[i] = (c[0] > 8'd252) ? c[0] - 8'($urandom_range(0, 2))
                               : c[0] + 8'($urandom_range(0, 2));
    end else if (kind < 45) begin
      for (int i = 0; i < 3; i++) begin
        case ($urandom_range(0, 3))
          0: c[i] = 8'd0;
          1: c[i] = 8'd1;
          2: c[i] = 8'd254;
          default: c[i] = 8'd255;
        endcase
      end
    end
    return {c[0], c[1], c[2]};
  endfunction

  // stimulus
  initial begin
    logic [23:0] rgb;
    int unsigned burst_left;
    rst_n     <= 1'b0;
    pix.valid <= 1'b0;
    pix.red   <= '0;
    pix.green <= '0;
    pix.blue  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (CornerPixels[i]) begin
      send_pixel(CornerPixels[i][23:16], CornerPixels[i][15:8], CornerPixels[i][7:0]);
    end
    wait_results_drained();

    burst_left = $urandom_range(1, 24);
    for (int i = 0; i < RandomPixels; i++) begin
      if (i == PausePixel) begin
        wait_results_drained();
      end else if (burst_left == 0 && !((i >= 280 && i < 520) || (i >= 880 && i < 1020))) begin
        // gaps stay out of the two streaming windows so the stall tests can fill the pipe
        pause_sender($urandom_range(1, 8));
        burst_left = $urandom_range(1, 24);
      end
      rgb = random_rgb();
      send_pixel(rgb[23:16], rgb[15:8], rgb[7:0]);
      if (burst_left != 0) burst_left--;
    end

    wait_results_drained();
    repeat (DrainCycles) @(posedge clk);
    $display("Checked %0d results for %0d pixels, %0d of them gray.", results, pixels, grays);
    $display("Covered corners, tied maxima, hue wrap, random gaps and full-pipe stalls.");
    if (fail_count == 0) begin
      $display("rgb_to_hsv_converter test passed");
    end else begin
      $display("rgb_to_hsv_converter test failed");
    end
    $finish;
  end

  // result side stall pattern, with two long hold-offs while the sender streams
  initial begin
    int unsigned mode;
    int unsigned len;
    int unsigned holds_done;
    holds_done = 0;
    hsv.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ((holds_done == 0 && pixels >= HoldAtFirst) ||
          (holds_done == 1 && pixels >= HoldAtSecond)) begin
        hsv.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        holds_done++;
      end else begin
        mode = $urandom_range(0, 3);
        len  = $urandom_range(1, 40);
        repeat (len) begin
          case (mode)
            0: hsv.ready <= 1'b1;
            1: hsv.ready <= 1'($urandom_range(0, 1));
            2: hsv.ready <= ($urandom_range(0, 3) == 0);
            default: hsv.ready <= ($urandom_range(0, 4) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (pix.valid && pix.ready) || (hsv.valid && hsv.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
      $display("rgb_to_hsv_converter test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
